[rtl/core/ffa_pkg.sv]
// shared types, constants and helper functions of the first-fit block allocator
package ffa_pkg;

    localparam int NUM_BLOCKS    = 1024;
    localparam int BLOCK_BYTES   = 16;
    localparam int WORD_BITS     = 64;

    localparam int SIZE_W        = 15;
    localparam int OFF_W         = 14;
    localparam int STAT_W        = 2;

    localparam int OFFSET_SPAN   = 1 << OFF_W;
    localparam int MAP_WORDS     = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int USABLE_BLOCKS = (NUM_BLOCKS < OFFSET_SPAN / BLOCK_BYTES) ?
                                   NUM_BLOCKS : OFFSET_SPAN / BLOCK_BYTES;
    localparam int LAST_WORD     = (USABLE_BLOCKS - 1) / WORD_BITS;

    localparam int BB_SH         = $clog2(BLOCK_BYTES);
    localparam int NEED_W        = $clog2(USABLE_BLOCKS + 1);
    localparam int WIDX_W        = $clog2(MAP_WORDS);
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int IDX_W         = WIDX_W + BIT_W;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_BAD_SIZE   = 2'd2,
        ST_BAD_OFFSET = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_FREE,
        K_REJECT
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic [NEED_W-1:0]  need;
        logic [IDX_W-1:0]   blk;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_PREV,
        S_WALK,
        S_CLEAR,
        S_RESP
    } t_state;

    // bits of a map word that belong to usable blocks
    function automatic logic [WORD_BITS-1:0] word_valid(input logic [WIDX_W-1:0] w);
        logic [WORD_BITS-1:0] m;
        m = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            m[j] = ((int'(w) * WORD_BITS + j) < USABLE_BLOCKS);
        end
        return m;
    endfunction

    // index of the lowest set bit
    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (v[j]) begin
                idx = BIT_W'(j);
            end
        end
        return idx;
    endfunction

    // index of the highest set bit
    function automatic logic [BIT_W-1:0] last_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (v[j]) begin
                idx = BIT_W'(j);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/core/ffa_front.sv]
// request front end: size rounding, range and alignment checks
module ffa_front (
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_func,
    input  logic [ffa_pkg::SIZE_W-1:0] i_size_bytes,
    input  logic [ffa_pkg::OFF_W-1:0]  i_offset_in,
    input  logic                      i_q_full,
    output logic                      o_push,
    output ffa_pkg::t_cmd             o_cmd
);
    import ffa_pkg::*;

    localparam int SUM_W = SIZE_W + 1;
    localparam int SBLK_W = OFF_W - BB_SH;

    logic [SUM_W-1:0]  size_sum;
    logic [SUM_W-1:0]  need_full;
    logic [SBLK_W-1:0] off_blk;
    logic              misaligned;

    assign size_sum   = SUM_W'(i_size_bytes) + SUM_W'(BLOCK_BYTES - 1);
    assign need_full  = size_sum >> BB_SH;
    assign off_blk    = SBLK_W'(i_offset_in >> BB_SH);
    assign misaligned = ((i_offset_in & OFF_W'(BLOCK_BYTES - 1)) != '0);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.kind   = K_ALLOC;
        o_cmd.status = ST_OK;
        o_cmd.need   = NEED_W'(need_full);
        o_cmd.blk    = IDX_W'(off_blk);
        if (!i_func) begin
            if (i_size_bytes == '0 || need_full > SUM_W'(USABLE_BLOCKS)) begin
                o_cmd.kind   = K_REJECT;
                o_cmd.status = ST_BAD_SIZE;
            end
        end else begin
            o_cmd.kind = K_FREE;
            if (misaligned || int'(off_blk) >= USABLE_BLOCKS) begin
                o_cmd.kind   = K_REJECT;
                o_cmd.status = ST_BAD_OFFSET;
            end
        end
    end

endmodule

[rtl/core/ffa_cmd_fifo.sv]
// small command queue between front end and map engine
module ffa_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ffa_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output ffa_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import ffa_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_push ? QPTR_W'(1) : '0);
        n_rd_ptr = r_rd_ptr + (do_pop ? QPTR_W'(1) : '0);
        n_count  = r_count + (i_push ? (QPTR_W + 1)'(1) : '0)
                           - (do_pop ? (QPTR_W + 1)'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/core/ffa_back.sv]
// map engine: word-serial first-fit search, run marking and run release
module ffa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  ffa_pkg::t_cmd               i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ffa_pkg::STAT_W-1:0]  o_status,
    output logic [ffa_pkg::OFF_W-1:0]   o_offset_out
);
    import ffa_pkg::*;

    localparam int CMP_W = NEED_W + 1;

    t_state             r_state, n_state;
    logic [WORD_BITS-1:0] r_used [MAP_WORDS];
    logic [WORD_BITS-1:0] r_end  [MAP_WORDS];
    logic [WIDX_W-1:0]  r_word, n_word;
    logic [NEED_W-1:0]  r_need, n_need;
    logic [NEED_W-1:0]  r_carry, n_carry;
    logic [IDX_W-1:0]   r_start, n_start;
    logic [IDX_W-1:0]   r_last, n_last;
    t_status            r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [OFF_W-1:0]   r_out_off, n_out_off;

    logic [WORD_BITS-1:0] cur_u, cur_e, vmask, free_w, pre, win, hit, rng, lo_mask, stop;
    logic [WORD_BITS-1:0] p_run, a_run, cmp, end_bit;
    logic [IDX_W-1:0]   base, scan_last, scan_start, walk_idx, prev_blk;
    logic [BIT_W-1:0]   hit_j, top_used, stop_j;
    logic [CMP_W-1:0]   carry_sum;
    logic               hit_any, stop_any, at_last_word, at_end_word, out_free;
    logic               prev_u, prev_e, map_we;
    logic [WORD_BITS-1:0] used_wr, end_wr;

    assign cur_u        = r_used[r_word];
    assign cur_e        = r_end[r_word];
    assign vmask        = word_valid(r_word);
    assign base         = {r_word, BIT_W'(0)};
    assign at_last_word = (r_word == WIDX_W'(LAST_WORD));
    assign at_end_word  = (r_word == r_last[IDX_W-1:BIT_W]);
    assign out_free     = !r_out_valid || i_out_ready;
    assign prev_blk     = r_start - IDX_W'(1);
    assign prev_u       = cur_u[prev_blk[BIT_W-1:0]];
    assign prev_e       = cur_e[prev_blk[BIT_W-1:0]];

    // run detection inside the current word
    always_comb begin
        free_w = ~cur_u & vmask;
        p_run  = free_w;
        a_run  = '1;
        for (int k = 0; k <= BIT_W; k++) begin
            if (r_need[k]) begin
                a_run = p_run & (a_run << (1 << k));
            end
            p_run = p_run & (p_run << (1 << k));
        end
        win = (r_need <= NEED_W'(WORD_BITS)) ? a_run : '0;
        pre = free_w & ~(free_w + WORD_BITS'(1));
        for (int j = 0; j < WORD_BITS; j++) begin
            cmp[j] = (CMP_W'(r_carry) + CMP_W'(j + 1)) >= CMP_W'(r_need);
            rng[j] = ((base | IDX_W'(j)) >= r_start) && ((base | IDX_W'(j)) <= r_last);
            lo_mask[j] = (r_word != r_start[IDX_W-1:BIT_W]) ||
                         (BIT_W'(j) >= r_start[BIT_W-1:0]);
        end
        hit        = win | (pre & cmp);
        hit_any    = (hit != '0);
        hit_j      = first_set(hit);
        scan_last  = base | IDX_W'(hit_j);
        scan_start = scan_last + IDX_W'(1) - IDX_W'(r_need);
        top_used   = last_set(~free_w);
        carry_sum  = CMP_W'(r_carry) + CMP_W'(WORD_BITS);
        stop       = (~cur_u | ~vmask | cur_e) & lo_mask;
        stop_any   = (stop != '0);
        stop_j     = first_set(stop);
        walk_idx   = base | IDX_W'(stop_j);
        end_bit    = WORD_BITS'(1) << r_last[BIT_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.kind)
                        K_ALLOC: n_state = S_SCAN;
                        K_FREE:  n_state = S_PREV;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit_any) begin
                    n_state = S_MARK;
                end else if (at_last_word) begin
                    n_state = S_RESP;
                end
            end
            S_MARK: begin
                if (at_end_word) begin
                    n_state = S_RESP;
                end
            end
            S_PREV: begin
                if (r_start != '0 && prev_u && !prev_e) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (stop_any) begin
                    n_state = (cur_u[stop_j] && vmask[stop_j]) ? S_CLEAR : S_RESP;
                end else if (at_last_word) begin
                    n_state = S_RESP;
                end
            end
            S_CLEAR: begin
                if (at_end_word) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and map writes
    always_comb begin
        n_word       = r_word;
        n_need       = r_need;
        n_carry      = r_carry;
        n_start      = r_start;
        n_last       = r_last;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_off    = r_out_off;
        o_q_pop      = 1'b0;
        map_we       = 1'b0;
        used_wr      = cur_u;
        end_wr       = cur_e;
        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                n_need  = i_q_cmd.need;
                n_start = i_q_cmd.blk;
                n_res   = i_q_cmd.status;
                n_carry = '0;
                if (i_q_cmd.kind == K_FREE) begin
                    n_word = WIDX_W'((i_q_cmd.blk - IDX_W'(1)) >> BIT_W);
                end else begin
                    n_word = '0;
                end
            end
            S_SCAN: begin
                if (hit_any) begin
                    n_start = scan_start;
                    n_last  = scan_last;
                    n_word  = scan_start[IDX_W-1:BIT_W];
                end else if (at_last_word) begin
                    n_res = ST_NO_SPACE;
                end else begin
                    n_word = r_word + WIDX_W'(1);
                    if (free_w == '1) begin
                        n_carry = (carry_sum > CMP_W'(USABLE_BLOCKS)) ?
                                  NEED_W'(USABLE_BLOCKS) : NEED_W'(carry_sum);
                    end else begin
                        n_carry = NEED_W'(WORD_BITS - 1) - NEED_W'(top_used);
                    end
                end
            end
            S_MARK: begin
                map_we  = 1'b1;
                used_wr = cur_u | rng;
                if (at_end_word) begin
                    end_wr = cur_e | end_bit;
                    n_res  = ST_OK;
                end else begin
                    n_word = r_word + WIDX_W'(1);
                end
            end
            S_PREV: begin
                n_word = r_start[IDX_W-1:BIT_W];
                n_res  = ST_BAD_OFFSET;
            end
            S_WALK: begin
                if (stop_any) begin
                    n_last = walk_idx;
                    n_word = r_start[IDX_W-1:BIT_W];
                end else if (!at_last_word) begin
                    n_word = r_word + WIDX_W'(1);
                end
            end
            S_CLEAR: begin
                map_we  = 1'b1;
                used_wr = cur_u & ~rng;
                if (at_end_word) begin
                    end_wr = cur_e & ~end_bit;
                    n_res  = ST_OK;
                end else begin
                    n_word = r_word + WIDX_W'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res;
                    n_out_off    = (r_res == ST_OK && r_need != '0) ?
                                   OFF_W'(r_start * BLOCK_BYTES) : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_used[w] <= '0;
                r_end[w]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (map_we) begin
                r_used[r_word] <= used_wr;
                r_end[r_word]  <= end_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word       <= n_word;
        r_carry      <= n_carry;
        r_start      <= n_start;
        r_last       <= n_last;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_off    <= n_out_off;
        // a free keeps need at zero so its reply carries no offset
        if (r_state == S_IDLE && i_q_valid && i_q_cmd.kind == K_FREE) begin
            r_need <= '0;
        end else begin
            r_need <= n_need;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_offset_out = r_out_off;

    // a run being marked must have been free
    a_mark_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> ((cur_u & rng) == '0))
        else $error("marking blocks already in use");

    // a run being released must be fully in use
    a_clear_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> ((cur_u & rng) == rng))
        else $error("releasing blocks not in use");

    // failed replies carry no offset
    a_fail_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_off == '0))
        else $error("offset on a failed reply");

    // the engine takes a new command only when idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE))
        else $error("command taken while busy");

endmodule

[rtl/core/first_fit_bitmap_allocator_core.sv]
// top level of the first-fit bitmap block allocator
// Allocates and frees runs of 16-byte blocks from a 1024-block pool, tracked by a used-bit map
// and an end-mark map (16 words of 64 bits each, cleared at reset). An allocate item rounds
// its byte count up to whole blocks and gets the byte offset of the lowest free run that fits;
// a free item names a run's start offset and releases it up to its end mark. One result item
// comes back per request, in request order. The front end checks sizes and offsets in the
// accept cycle and hands commands to a two-entry queue; the map engine then works one map
// word per cycle. A rejected request goes straight to its result; an allocate scans map
// words up to the hit and then marks each word that the run spans; a free checks the block
// before its start, walks words up to the end mark and then releases each word of the run.
// The result sits in an output register, so the next item is taken while a finished result
// waits.
module first_fit_bitmap_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [ffa_pkg::SIZE_W-1:0]  i_size_bytes,
    input  logic [ffa_pkg::OFF_W-1:0]   i_offset_in,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ffa_pkg::STAT_W-1:0]  o_status,
    output logic [ffa_pkg::OFF_W-1:0]   o_offset_out
);
    import ffa_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    // classify and check each item as it arrives
    ffa_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_size_bytes (i_size_bytes),
        .i_offset_in  (i_offset_in),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    // decouples front end from the map engine
    ffa_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // bitmap search, mark and release
    ffa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_offset_out (o_offset_out)
    );

endmodule

[verif/tb_top.sv]
// self-checking testbench of the first-fit bitmap block allocator
module tb_top;
    import ffa_pkg::*;

    localparam int ALLOC = 0;
    localparam int FREE  = 1;

    // predictor of the pool and store of expected results
    class pool_scoreboard;
        bit       used [USABLE_BLOCKS];
        bit       endm [USABLE_BLOCKS];
        t_status  exp_status [$];
        logic [OFF_W-1:0] exp_offset [$];
        int       errors;
        int       checked;
        int       live_starts [$];

        function void clear_pool();
            foreach (used[b]) begin
                used[b] = 0;
                endm[b] = 0;
            end
            live_starts.delete();
        endfunction

        function void note_request(bit func, int size, int off);
            t_status st;
            int      res;
            int      need;
            int      run;
            int      start;
            bit      done;
            st = ST_OK;
            res = 0;
            done = 0;
            if (func == ALLOC) begin
                need = (size + BLOCK_BYTES - 1) / BLOCK_BYTES;
                if (size == 0 || need > USABLE_BLOCKS) begin
                    st = ST_BAD_SIZE;
                end else begin
                    st = ST_NO_SPACE;
                    run = 0;
                    for (int b = 0; b < USABLE_BLOCKS && !done; b++) begin
                        run = used[b] ? 0 : run + 1;
                        if (run == need) begin
                            start = b + 1 - need;
                            for (int i = start; i <= b; i++) used[i] = 1;
                            endm[b] = 1;
                            st = ST_OK;
                            res = (start * BLOCK_BYTES) & 16'h3fff;
                            live_starts.push_back(res);
                            done = 1;
                        end
                    end
                end
            end else begin
                st = ST_BAD_OFFSET;
                start = off / BLOCK_BYTES;
                if (off % BLOCK_BYTES == 0 && start < USABLE_BLOCKS && used[start] &&
                    !(start > 0 && used[start-1] && !endm[start-1])) begin
                    for (int b = start; b < USABLE_BLOCKS && !done; b++) begin
                        if (!used[b]) begin
                            done = 1;
                        end else if (endm[b]) begin
                            for (int i = start; i <= b; i++) used[i] = 0;
                            endm[b] = 0;
                            st = ST_OK;
                            done = 1;
                            foreach (live_starts[k])
                                if (live_starts[k] == off) begin
                                    live_starts.delete(k);
                                    break;
                                end
                        end
                    end
                end
            end
            exp_status.push_back(st);
            exp_offset.push_back(res[OFF_W-1:0]);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [OFF_W-1:0] off);
            t_status          es;
            logic [OFF_W-1:0] eo;
            if (exp_status.size() == 0) begin
                $display("%0t: unexpected result status=%0d offset=%0d", $time, st, off);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            eo = exp_offset.pop_front();
            checked++;
            if (st !== es) begin
                $display("%0t: status mismatch expected=%0d actual=%0d", $time, es, st);
                errors++;
            end
            if (off !== eo) begin
                $display("%0t: offset mismatch expected=%0d actual=%0d", $time, eo, off);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              func;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  offset_in;
    logic              out_valid;
    logic              out_ready;
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  offset_out;

    pool_scoreboard pool;
    bit  calm;          // no idling in the last part of the run
    bit  hold_off;      // long receiver stall requested
    int  sent;

    first_fit_bitmap_allocator_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_func       (func),
        .i_size_bytes (size_bytes),
        .i_offset_in  (offset_in),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_offset_out (offset_out)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #30000000;
        $display("tb: failure");
        $finish;
    end

    // present one item and hold it until taken, with an optional gap first
    task automatic send_request(bit f, int size, int off);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1;
        func       <= f;
        size_bytes <= size[SIZE_W-1:0];
        offset_in  <= off[OFF_W-1:0];
        do @(posedge clk); while (!in_ready);
        pool.note_request(f, size, off);
        sent++;
    endtask

    task automatic send_alloc(int size);
        send_request(ALLOC, size, $urandom_range(0, 16383));
    endtask

    task automatic send_free(int off);
        send_request(FREE, $urandom_range(0, 32767), off);
    endtask

    // random free target: mostly live run starts, sometimes noise
    function automatic int pick_free_offset();
        int r;
        r = $urandom_range(0, 9);
        if (pool.live_starts.size() > 0 && r < 7)
            return pool.live_starts[$urandom_range(0, pool.live_starts.size() - 1)];
        if (r < 9)
            return $urandom_range(0, USABLE_BLOCKS - 1) * BLOCK_BYTES;
        return $urandom_range(0, 16383);
    endfunction

    // mostly small sizes, a few large and out-of-range ones
    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 160);
        if (r < 90) return $urandom_range(1, 2048);
        if (r < 97) return $urandom_range(1, 16384);
        return $urandom_range(16385, 32767);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        out_ready <= 0;
        @(posedge clk);
        forever begin
            if (hold_off) begin
                out_ready <= 0;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17);
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end else begin
                out_ready <= 1;
                @(posedge clk);
                if (out_valid && out_ready)
                    pool.check_result(status, offset_out);
            end
        end
    end

    initial begin
        int waited;
        pool = new();
        pool.clear_pool();
        calm = 0;
        hold_off = 0;
        sent = 0;
        rst_n      <= 0;
        in_valid   <= 0;
        func       <= 0;
        size_bytes <= 0;
        offset_in  <= 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: size extremes, each reject case, run freeing
        send_alloc(0);
        send_alloc(16385);
        send_alloc(32767);
        send_alloc(1);
        send_alloc(16);
        send_alloc(17);
        send_free(1);
        send_free(16383);
        send_free(48);          // middle of a run
        send_free(32);          // run start, two blocks
        send_free(32);          // already free
        send_alloc(16384);      // whole pool, no space now
        send_free(0);
        send_free(16);
        send_alloc(16384);      // whole pool fits
        send_alloc(1);          // no space
        send_free(0);
        send_alloc(16368);      // all but last block
        send_alloc(16);         // last block
        send_free(16368);
        send_free(0);
        send_free(0);

        // long receiver hold-off while items keep coming
        hold_off = 1;
        repeat (20) send_alloc($urandom_range(1, 64));

        while (sent < 1100) begin
            if (sent > 950) calm = 1;
            if ($urandom_range(0, 1) == 0) send_alloc(pick_size());
            else send_free(pick_free_offset());
        end
        in_valid <= 0;

        waited = 0;
        while (pool.exp_status.size() > 0 && waited < 100000) begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        $display("tb: %0d requests sent, %0d results checked", sent, pool.checked);
        $display("tb: allocate and free with random sizes, reject cases and output stalls");
        if (pool.errors == 0 && pool.exp_status.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[first_fit_bitmap_allocator_core.f]
rtl/core/ffa_pkg.sv
rtl/core/ffa_front.sv
rtl/core/ffa_cmd_fifo.sv
rtl/core/ffa_back.sv
rtl/core/first_fit_bitmap_allocator_core.sv
verif/tb_top.sv
